[rtl/rwns_pkg.sv]
// Package for the random walk node sampler.
// Holds the port widths, the item kind codes, the register indexes and parameter defaults.
// Depends on nothing.
`default_nettype none
package rwns_pkg;
  localparam int unsigned DefMaxNodes = 1024;
  localparam int unsigned DefMaxEdges = 8192;

  localparam int unsigned KindW      = 2;
  localparam int unsigned AddrW      = 13;
  localparam int unsigned DataW      = 14;
  localparam int unsigned RandW      = 31;
  localparam int unsigned NodeOutW   = 10;
  localparam int unsigned CountW     = 9;
  localparam int unsigned NodeCountW = 11;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [KindW-1:0] KIND_LOAD_OFFSET   = 2'd0;
  localparam logic [KindW-1:0] KIND_LOAD_NEIGHBOR = 2'd1;
  localparam logic [KindW-1:0] KIND_START         = 2'd2;
  localparam logic [KindW-1:0] KIND_STEP          = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_NODE_COUNT     = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_REQUIRED_COUNT = 1'b1;
endpackage
`default_nettype wire

[rtl/rwns_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none
module rwns_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/random_walk_node_sampler.sv]
// Random walk node sampler over a graph held in compressed sparse row form.
// A load item leaves the block idle. A start item, and reset, sweep the visited map at one
// entry a cycle, keeping the block busy. A step item does nothing when sampling is complete.
// Otherwise a restart from an inactive walk runs the remainder unit, then reads and checks the
// visited map; a zero degree node forces it after the offset reads. A neighbor walk reads the
// offsets, runs the remainder unit, then for each probed neighbor reads and checks its id, and
// reads the visited map unless the id is outside the node count. Both use the bit-serial
// remainder unit (one random bit a cycle) and the one-read-per-cycle ports of the offset,
// neighbor and visited memories. Results are strobed for one cycle and cannot be stalled.
`default_nettype none
module random_walk_node_sampler
  import rwns_pkg::*;
#(
  parameter int unsigned MAX_NODES = DefMaxNodes,
  parameter int unsigned MAX_EDGES = DefMaxEdges
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  output logic                  busy_o,
  input  wire [KindW-1:0]       kind_i,
  input  wire [AddrW-1:0]       addr_i,
  input  wire [DataW-1:0]       data_i,
  input  wire [RandW-1:0]       random_i,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire [CfgIdxW-1:0]     cfg_index_i,
  input  wire [NodeCountW-1:0]  cfg_data_i,
  output logic                  out_valid_o,
  output logic [NodeOutW-1:0]   node_o,
  output logic [CountW-1:0]     count_o,
  output logic                  done_res_o
);
  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned CW  = NW + 1;
  localparam int unsigned OAW = $clog2(MAX_NODES + 1);
  localparam int unsigned EW  = $clog2(MAX_EDGES);
  localparam int unsigned DW  = (CW > DataW) ? CW : DataW;
  localparam int unsigned BW  = $clog2(RandW);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LO, S_HI, S_DEG, S_DIV, S_RVIS, S_RCHK, S_NB, S_NBCHK, S_VIS, S_VCHK
  } state_e;

  state_e           state_q;
  logic [CW-1:0]    n_q;
  logic [NW-1:0]    cur_q, nb_q, clr_q;
  logic             active_q, probe_q, idx_ok_q;
  logic [CountW-1:0] samples_q, required_q;
  logic [NodeCountW-1:0] node_count_q;
  logic [DataW-1:0] lo_q;
  logic [DW-1:0]    div_q, rem_q, deg_q, i_q, first_q;
  logic [RandW-1:0] rnd_q;
  logic [BW-1:0]    bit_q;
  logic             out_valid_q, done_q;
  logic [NodeOutW-1:0] node_q;

  logic accept, off_we, nbr_we, vis_we;
  logic [DataW-1:0] off_rdata;
  logic [NW-1:0]    nbr_rdata, vis_addr, vis_waddr;
  logic             vis_rdata, vis_wdata;
  logic [OAW-1:0]   off_raddr;
  logic [DW:0]      idx, shifted;
  logic [DW-1:0]    rem_nx, deg_calc, i_nx;
  logic [CW-1:0]    n_calc;
  logic [NW-1:0]    nb_val;
  logic [CountW-1:0] samples_inc;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign off_we = accept && (kind_i == KIND_LOAD_OFFSET) && (32'(addr_i) < MAX_NODES + 1);
  assign nbr_we = accept && (kind_i == KIND_LOAD_NEIGHBOR) && (32'(addr_i) < MAX_EDGES);

  always_comb begin
    if (node_count_q == '0) begin
      n_calc = CW'(1);
    end else if (32'(node_count_q) > MAX_NODES) begin
      n_calc = CW'(MAX_NODES);
    end else begin
      n_calc = CW'(node_count_q);
    end
  end

  assign off_raddr = (state_q == S_LO) ? OAW'(cur_q) : OAW'(cur_q) + OAW'(1);
  assign deg_calc  = (off_rdata > lo_q) ? DW'(off_rdata - lo_q) : '0;
  assign shifted   = {rem_q, rnd_q[RandW-1]};
  assign rem_nx    = (shifted >= {1'b0, div_q}) ? DW'(shifted - {1'b0, div_q}) : DW'(shifted);
  assign idx       = (DW+1)'(lo_q) + (DW+1)'(i_q);
  assign i_nx      = (i_q + DW'(1) == deg_q) ? '0 : i_q + DW'(1);
  assign nb_val    = idx_ok_q ? nbr_rdata : '0;
  assign samples_inc = samples_q + CountW'(1);

  assign vis_addr  = (state_q == S_VIS || state_q == S_VCHK) ? nb_q : cur_q;
  assign vis_we    = (state_q == S_CLEAR) ||
                     ((state_q == S_RCHK || state_q == S_VCHK) && !vis_rdata);
  assign vis_waddr = (state_q == S_CLEAR) ? clr_q : vis_addr;
  assign vis_wdata = (state_q != S_CLEAR);

  rwns_ram #(.Width(DataW), .Depth(MAX_NODES + 1)) u_offset_ram (
    .clk_i, .we_i(off_we), .waddr_i(OAW'(addr_i)), .wdata_i(data_i),
    .raddr_i(off_raddr), .rdata_o(off_rdata)
  );

  rwns_ram #(.Width(NW), .Depth(MAX_EDGES)) u_neighbor_ram (
    .clk_i, .we_i(nbr_we), .waddr_i(EW'(addr_i)), .wdata_i(NW'(data_i[9:0])),
    .raddr_i(EW'(idx)), .rdata_o(nbr_rdata)
  );

  rwns_ram #(.Width(1), .Depth(MAX_NODES)) u_visited_ram (
    .clk_i, .we_i(vis_we), .waddr_i(vis_waddr), .wdata_i(vis_wdata),
    .raddr_i(vis_addr), .rdata_o(vis_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountW'(1024);
      required_q   <= CountW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_NODE_COUNT:     node_count_q <= cfg_data_i;
        CFG_REQUIRED_COUNT: required_q   <= cfg_data_i[CountW-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cur_q       <= '0;
      active_q    <= 1'b0;
      samples_q   <= '0;
      out_valid_q <= 1'b0;
      probe_q     <= 1'b0;
      bit_q       <= '0;
    end else begin
      out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + NW'(1);
          if (32'(clr_q) == MAX_NODES - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && kind_i == KIND_START) begin
            clr_q     <= '0;
            samples_q <= '0;
            active_q  <= 1'b0;
            cur_q     <= '0;
            state_q   <= S_CLEAR;
          end else if (accept && kind_i == KIND_STEP && samples_q < required_q) begin
            n_q   <= n_calc;
            rnd_q <= random_i;
            rem_q <= '0;
            bit_q <= '0;
            if (active_q && CW'(cur_q) < n_calc) begin
              state_q <= S_LO;
            end else begin
              div_q   <= DW'(n_calc);
              probe_q <= 1'b0;
              state_q <= S_DIV;
            end
          end
        end
        S_LO: state_q <= S_HI;
        S_HI: begin
          lo_q    <= off_rdata;
          state_q <= S_DEG;
        end
        S_DEG: begin
          if (deg_calc == '0) begin
            div_q   <= DW'(n_q);
            probe_q <= 1'b0;
          end else begin
            div_q   <= deg_calc;
            deg_q   <= deg_calc;
            probe_q <= 1'b1;
          end
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= rem_nx;
          rnd_q <= {rnd_q[RandW-2:0], 1'b0};
          bit_q <= bit_q + BW'(1);
          if (32'(bit_q) == RandW - 1) begin
            if (probe_q) begin
              i_q     <= rem_nx;
              first_q <= rem_nx;
              state_q <= S_NB;
            end else begin
              cur_q    <= NW'(rem_nx);
              active_q <= 1'b1;
              state_q  <= S_RVIS;
            end
          end
        end
        S_RVIS: state_q <= S_RCHK;
        S_RCHK: begin
          if (!vis_rdata) begin
            samples_q   <= samples_inc;
            out_valid_q <= 1'b1;
            node_q      <= NodeOutW'(cur_q);
            done_q      <= (samples_inc >= required_q);
          end
          state_q <= S_IDLE;
        end
        S_NB: begin
          idx_ok_q <= (32'(idx) < MAX_EDGES);
          state_q  <= S_NBCHK;
        end
        S_NBCHK: begin
          if (CW'(nb_val) < n_q) begin
            nb_q    <= nb_val;
            state_q <= S_VIS;
          end else if (i_nx == first_q) begin
            active_q <= 1'b0;
            state_q  <= S_IDLE;
          end else begin
            i_q     <= i_nx;
            state_q <= S_NB;
          end
        end
        S_VIS: state_q <= S_VCHK;
        S_VCHK: begin
          if (!vis_rdata) begin
            cur_q       <= nb_q;
            samples_q   <= samples_inc;
            out_valid_q <= 1'b1;
            node_q      <= NodeOutW'(nb_q);
            done_q      <= (samples_inc >= required_q);
            state_q     <= S_IDLE;
          end else if (i_nx == first_q) begin
            active_q <= 1'b0;
            state_q  <= S_IDLE;
          end else begin
            i_q     <= i_nx;
            state_q <= S_NB;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign node_o      = node_q;
  assign count_o     = samples_q;
  assign done_res_o  = done_q;

`ifndef NO_ASSERTIONS
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |=> !out_valid_q) else $error("two results in a row");
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> samples_q != '0) else $error("result with zero count");
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == KIND_START) |=> (busy_o && samples_q == '0 && !active_q))
    else $error("start item did not clear the walk");
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == S_IDLE) else $error("result while still busy");
`endif
endmodule
`default_nettype wire
